// ===== design/szc_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and types for the two-port S to Z conversion unit.
// No dependencies; imported by every module of the block.
package szc_pkg;

  localparam int SW     = 24;           // input S terms, Q8.16
  localparam int TW     = 25;           // 1 +/- S terms
  localparam int NW     = 52;           // second-order terms, Q.32
  localparam int HW     = 26;           // split point of the wide multiplier
  localparam int PRW    = 2 * NW;       // wide product
  localparam int AW     = PRW + 1;      // sum of two wide products
  localparam int DENW   = PRW;          // |Delta|^2, unsigned
  localparam int QW     = 32;           // result width, Q16.16
  localparam int FRAC   = 16;
  localparam int NSTEP  = QW;           // one quotient bit per divider stage
  localparam int NPROD  = 16;           // narrow products in the front end
  localparam int NWIDE  = 18;           // wide products
  localparam int NZ     = 8;            // result components

  localparam int ONE_Q16 = 65536;
  localparam logic signed [TW-1:0] ONE_T = TW'(ONE_Q16);
  localparam logic [QW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] SAT_NEG = 32'h8000_0000;

  // pipeline stage map
  localparam int ST_MUL     = 2;
  localparam int ST_CMB     = 4;
  localparam int ST_DIV     = 5;
  localparam int DIV_STAGES = NSTEP + 2;
  localparam int STAGES     = ST_DIV + DIV_STAGES;

  typedef logic signed [NW-1:0]  term_t;
  typedef logic signed [PRW-1:0] prod_t;
  typedef logic signed [AW-1:0]  acc_t;

  typedef struct packed {
    term_t dr;
    term_t di;
    term_t n11r;
    term_t n11i;
    term_t a21r;
    term_t a21i;
    term_t a12r;
    term_t a12i;
    term_t n22r;
    term_t n22i;
  } szc_terms_t;

endpackage

// ===== design/two_port_s_to_z_conversion_unit.sv =====
`timescale 1ns / 1ps
// Top level of the two-port S to normalized Z conversion unit.
// Depends on szc_pkg, szc_front, szc_wmul and szc_div.

// Converts one frequency point of a two-port S-matrix (eight Q8.16 numbers)
// to the normalized Z-matrix (eight Q16.16 numbers) and a singular flag.
// The unit is a fully pipelined datapath: while the output is not stalled, a
// request can be taken on every clock, so the sustained rate is one frequency
// point per cycle; most of the pipeline lies in the divider, which forms one
// quotient bit per stage. Nothing is held between requests.
// Each pipeline stage carries a valid bit and advances when it is empty or
// the stage after it advances, so the unit keeps taking requests while a
// finished result waits at the output, until every stage is full; a stall
// holds the last stage and the run of full stages behind it. When Delta is
// exactly zero, all Z fields are zero and the singular flag is set. Quotients
// truncate toward zero and saturate to the 32-bit signed range.
module two_port_s_to_z_conversion_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // s11_re, s11_im, s21_re, s21_im, s12_re, s12_im, s22_re, s22_im (24 b each)
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // z11_re, z11_im, z21_re, z21_im, z12_re, z12_im, z22_re, z22_im (32 b each)
  output logic [255:0] m_axis_tdata,
  // singular
  output logic         m_axis_tuser
);
  import szc_pkg::*;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;

  szc_terms_t terms;
  term_t      wa [NWIDE];
  term_t      wb [NWIDE];
  prod_t      wp [NWIDE];
  term_t      nre [4];
  term_t      nim [4];
  acc_t       num [NZ];
  logic [DENW-1:0] den;
  logic       zero2, zero3, zero4;
  logic [QW-1:0] zq [NZ];
  logic       zflag [NZ];

  // A stage advances when empty or when the stage after it advances.
  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) adv[k] = !vld[k] || adv[k+1];
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = vld[STAGES-1];

  // Move the valid bits along with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  szc_front u_front (
    .clk    (clk),
    .adv    (adv[1:0]),
    .s11_re (s_axis_tdata[23:0]),
    .s11_im (s_axis_tdata[47:24]),
    .s21_re (s_axis_tdata[71:48]),
    .s21_im (s_axis_tdata[95:72]),
    .s12_re (s_axis_tdata[119:96]),
    .s12_im (s_axis_tdata[143:120]),
    .s22_re (s_axis_tdata[167:144]),
    .s22_im (s_axis_tdata[191:168]),
    .terms  (terms)
  );

  // Hold the singular flag alongside the wide products.
  always_ff @(posedge clk) begin
    if (adv[ST_MUL])     zero2 <= (terms.dr == '0) && (terms.di == '0);
    if (adv[ST_MUL + 1]) zero3 <= zero2;
    if (adv[ST_CMB])     zero4 <= zero3;
  end

  // Wide product list: |Delta|^2 terms first, then per result
  // nr*dr, ni*di, ni*dr, nr*di.
  always_comb begin
    nre[0] = terms.n11r; nim[0] = terms.n11i;
    nre[1] = terms.a21r; nim[1] = terms.a21i;
    nre[2] = terms.a12r; nim[2] = terms.a12i;
    nre[3] = terms.n22r; nim[3] = terms.n22i;
    wa[0] = terms.dr; wb[0] = terms.dr;
    wa[1] = terms.di; wb[1] = terms.di;
    for (int c = 0; c < 4; c++) begin
      wa[2+4*c] = nre[c]; wb[2+4*c] = terms.dr;
      wa[3+4*c] = nim[c]; wb[3+4*c] = terms.di;
      wa[4+4*c] = nim[c]; wb[4+4*c] = terms.dr;
      wa[5+4*c] = nre[c]; wb[5+4*c] = terms.di;
    end
  end

  for (genvar g = 0; g < NWIDE; g++) begin : g_wmul
    szc_wmul u_wmul (
      .clk (clk),
      .adv (adv[ST_MUL+1:ST_MUL]),
      .a   (wa[g]),
      .b   (wb[g]),
      .p   (wp[g])
    );
  end

  // Form |Delta|^2 and N * conj(Delta) for every component.
  always_ff @(posedge clk) begin
    if (adv[ST_CMB]) begin
      den <= DENW'(wp[0]) + DENW'(wp[1]);
      for (int c = 0; c < 4; c++) begin
        num[2*c]   <= AW'(wp[2+4*c]) + AW'(wp[3+4*c]);
        num[2*c+1] <= AW'(wp[4+4*c]) - AW'(wp[5+4*c]);
      end
    end
  end

  for (genvar g = 0; g < NZ; g++) begin : g_div
    szc_div u_div (
      .clk      (clk),
      .adv      (adv[STAGES-1:ST_DIV]),
      .num      (num[g]),
      .den      (den),
      .zero     (zero4),
      .z        (zq[g]),
      .zero_out (zflag[g])
    );
    assign m_axis_tdata[QW*g +: QW] = zq[g];
  end

  assign m_axis_tuser = zflag[0];

endmodule

// ===== design/szc_front.sv =====
`timescale 1ns / 1ps
// Front end: 1 +/- S terms, narrow products, then Delta and the numerators.
// Depends on szc_pkg.
module szc_front (
  input  logic                             clk,
  input  logic [1:0]                       adv,
  input  logic signed [szc_pkg::SW-1:0]    s11_re,
  input  logic signed [szc_pkg::SW-1:0]    s11_im,
  input  logic signed [szc_pkg::SW-1:0]    s21_re,
  input  logic signed [szc_pkg::SW-1:0]    s21_im,
  input  logic signed [szc_pkg::SW-1:0]    s12_re,
  input  logic signed [szc_pkg::SW-1:0]    s12_im,
  input  logic signed [szc_pkg::SW-1:0]    s22_re,
  input  logic signed [szc_pkg::SW-1:0]    s22_im,
  output szc_pkg::szc_terms_t              terms
);
  import szc_pkg::*;

  logic signed [TW-1:0] m11r, m11i, m22r, m22i, p11r, p11i, p22r, p22i;
  logic signed [TW-1:0] s12r, s12i, s21r, s21i;
  logic signed [TW-1:0] opa [NPROD];
  logic signed [TW-1:0] opb [NPROD];
  logic signed [2*TW-1:0] pr [NPROD];
  logic signed [SW-1:0] s21r_q, s21i_q, s12r_q, s12i_q;
  term_t xr, xi;
  szc_terms_t terms_next;

  assign m11r = ONE_T - TW'(s11_re);
  assign m11i = -TW'(s11_im);
  assign m22r = ONE_T - TW'(s22_re);
  assign m22i = -TW'(s22_im);
  assign p11r = ONE_T + TW'(s11_re);
  assign p11i = TW'(s11_im);
  assign p22r = ONE_T + TW'(s22_re);
  assign p22i = TW'(s22_im);
  assign s12r = TW'(s12_re);
  assign s12i = TW'(s12_im);
  assign s21r = TW'(s21_re);
  assign s21i = TW'(s21_im);

  always_comb begin
    opa[0]  = s12r; opb[0]  = s21r;
    opa[1]  = s12i; opb[1]  = s21i;
    opa[2]  = s12r; opb[2]  = s21i;
    opa[3]  = s12i; opb[3]  = s21r;
    opa[4]  = m11r; opb[4]  = m22r;
    opa[5]  = m11i; opb[5]  = m22i;
    opa[6]  = m11r; opb[6]  = m22i;
    opa[7]  = m11i; opb[7]  = m22r;
    opa[8]  = p11r; opb[8]  = m22r;
    opa[9]  = p11i; opb[9]  = m22i;
    opa[10] = p11r; opb[10] = m22i;
    opa[11] = p11i; opb[11] = m22r;
    opa[12] = m11r; opb[12] = p22r;
    opa[13] = m11i; opb[13] = p22i;
    opa[14] = m11r; opb[14] = p22i;
    opa[15] = m11i; opb[15] = p22r;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int k = 0; k < NPROD; k++) pr[k] <= opa[k] * opb[k];
      s21r_q <= s21_re;
      s21i_q <= s21_im;
      s12r_q <= s12_re;
      s12i_q <= s12_im;
    end
  end

  // sum the products into Delta, the numerators and the scaled S21, S12
  always_comb begin
    xr = NW'(pr[0]) - NW'(pr[1]);
    xi = NW'(pr[2]) + NW'(pr[3]);
    terms_next.dr   = NW'(pr[4]) - NW'(pr[5]) - xr;
    terms_next.di   = NW'(pr[6]) + NW'(pr[7]) - xi;
    terms_next.n11r = NW'(pr[8]) - NW'(pr[9]) + xr;
    terms_next.n11i = NW'(pr[10]) + NW'(pr[11]) + xi;
    terms_next.n22r = NW'(pr[12]) - NW'(pr[13]) + xr;
    terms_next.n22i = NW'(pr[14]) + NW'(pr[15]) + xi;
    terms_next.a21r = NW'(s21r_q) <<< (FRAC + 1);
    terms_next.a21i = NW'(s21i_q) <<< (FRAC + 1);
    terms_next.a12r = NW'(s12r_q) <<< (FRAC + 1);
    terms_next.a12i = NW'(s12i_q) <<< (FRAC + 1);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      terms <= terms_next;
    end
  end

endmodule

// ===== design/szc_wmul.sv =====
`timescale 1ns / 1ps
// Two-stage signed wide multiplier built from four half-width partial products.
// Depends on szc_pkg.
module szc_wmul (
  input  logic                  clk,
  input  logic [1:0]            adv,
  input  szc_pkg::term_t        a,
  input  szc_pkg::term_t        b,
  output szc_pkg::prod_t        p
);
  import szc_pkg::*;

  logic signed [NW-HW-1:0]   ah, bh;
  logic signed [HW:0]        al, bl;
  logic signed [2*(NW-HW)-1:0] pp_hh;
  logic signed [NW:0]          pp_hl, pp_lh;
  logic signed [2*HW+1:0]      pp_ll;

  assign ah = a[NW-1:HW];
  assign bh = b[NW-1:HW];
  assign al = {1'b0, a[HW-1:0]};
  assign bl = {1'b0, b[HW-1:0]};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pp_hh <= ah * bh;
      pp_hl <= ah * bl;
      pp_lh <= al * bh;
      pp_ll <= al * bl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      p <= (PRW'(pp_hh) <<< (2 * HW)) + ((PRW'(pp_hl) + PRW'(pp_lh)) <<< HW)
           + PRW'(pp_ll);
    end
  end

endmodule

// ===== design/szc_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider: signed numerator over |Delta|^2, Q16.16 result,
// truncated toward zero and saturated. Depends on szc_pkg.
module szc_div (
  input  logic                            clk,
  input  logic [szc_pkg::DIV_STAGES-1:0]  adv,
  input  szc_pkg::acc_t                   num,
  input  logic [szc_pkg::DENW-1:0]        den,
  input  logic                            zero,
  output logic [szc_pkg::QW-1:0]          z,
  output logic                            zero_out
);
  import szc_pkg::*;

  logic [DENW-1:0]  rem    [NSTEP+1];
  logic [DENW-1:0]  den_s  [NSTEP+1];
  logic [NSTEP-1:0] low    [NSTEP+1];
  logic [QW-1:0]    q      [NSTEP+1];
  logic             neg    [NSTEP+1];
  logic             ovf    [NSTEP+1];
  logic             zero_s [NSTEP+1];
  logic [DENW-1:0]  mag;
  logic             num_neg;
  acc_t             num_abs;

  assign num_neg = num[AW-1];
  assign num_abs = num_neg ? -num : num;
  assign mag     = DENW'(num_abs);

  // take the magnitude; a quotient of 2^32 or more is flagged up front
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem[0]    <= mag >> FRAC;
      low[0]    <= {mag[FRAC-1:0], {(NSTEP-FRAC){1'b0}}};
      den_s[0]  <= den;
      q[0]      <= '0;
      neg[0]    <= num_neg;
      ovf[0]    <= (mag >> FRAC) >= den;
      zero_s[0] <= zero;
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [DENW:0] t;
    logic          ge;
    assign t  = {rem[k-1], low[k-1][NSTEP-1]};
    assign ge = t >= {1'b0, den_s[k-1]};
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem[k]    <= ge ? DENW'(t - {1'b0, den_s[k-1]}) : DENW'(t);
        low[k]    <= low[k-1] << 1;
        den_s[k]  <= den_s[k-1];
        q[k]      <= {q[k-1][QW-2:0], ge};
        neg[k]    <= neg[k-1];
        ovf[k]    <= ovf[k-1];
        zero_s[k] <= zero_s[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NSTEP+1]) begin
      zero_out <= zero_s[NSTEP];
      if (zero_s[NSTEP]) begin
        z <= '0;
      end else if (neg[NSTEP]) begin
        z <= (ovf[NSTEP] || q[NSTEP] > SAT_NEG) ? SAT_NEG : -q[NSTEP];
      end else begin
        z <= (ovf[NSTEP] || q[NSTEP][QW-1]) ? SAT_POS : q[NSTEP];
      end
    end
  end

endmodule
